// File: hdl/fpba_pkg.sv
// Package with the item types, sizes and status codes of the fit policy block allocator.
`default_nettype none
package fpba_pkg;
    localparam int MAX_ENTRIES = 32;
    localparam int ARENA_BITS  = 20;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_NOENTRY = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_NEXT  = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_ARENA  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [20:0] request_bytes;
        logic [19:0] free_offset;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] block_offset;
        logic [5:0]  entries_in_use;
    } t_out_item;

    // Classified command passed from the front part to the back part.
    typedef struct packed {
        logic        is_free;
        logic        reject;
        logic [21:0] size;
        logic [19:0] where;
    } t_cmd;
endpackage
`default_nettype wire

// File: hdl/fit_policy_block_allocator.sv
// Top level of the fit policy block allocator: configuration registers, front and back parts.
// An item passes from the front part's queue to the back part, which walks the linked ledger
// one entry per cycle, then places a block with any split in S_ALLOC or performs merges in
// S_MRG1 and S_MRG2, then delivers the result from S_DONE; a rejected
// request skips the walk. Configuration writes are accepted only while no item is in flight
// and reinitialise the ledger.
`default_nettype none
module fit_policy_block_allocator
    import fpba_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [20:0] i_cfg_data
);
    logic [1:0]  r_policy;
    logic [21:0] r_arena;
    logic        w_cfg_wr, w_cmd_valid, w_cmd_ready, w_idle;
    t_cmd        w_cmd;
    logic [21:0] w_arena;

    assign o_cfg_ready = w_idle && !w_cmd_valid;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_comb begin
        w_arena = ({1'b0, i_cfg_data} + 22'd3) & ~22'd3;
        if (w_arena < 22'd4) begin
            w_arena = 22'd4;
        end
        if (w_arena > (22'd1 << ARENA_BITS)) begin
            w_arena = 22'd1 << ARENA_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIRST;
            r_arena  <= (22'd1048576 > (22'd1 << ARENA_BITS)) ? (22'd1 << ARENA_BITS)
                                                             : 22'd1048576;
        end else if (w_cfg_wr) begin
            if (i_cfg_index == CFG_POLICY) begin
                r_policy <= i_cfg_data[1:0];
            end else begin
                r_arena <= w_arena;
            end
        end
    end

    fpba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    fpba_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_init      (w_cfg_wr),
        .i_policy    (r_policy),
        .i_arena     ((w_cfg_wr && i_cfg_index == CFG_ARENA) ? w_arena : r_arena),
        .o_idle      (w_idle),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    property p_cfg_idle;
        @(posedge i_clk) disable iff (!i_rst_n) w_cfg_wr |=> w_idle;
    endproperty
    a_cfg_idle: assert property (p_cfg_idle) else $error("back part busy after configuration");
endmodule
`default_nettype wire

// File: hdl/fpba_front.sv
// Front part: accepts items, rounds sizes and classifies them into a two-entry queue.
`default_nettype none
module fpba_front
    import fpba_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_ready,
    output t_cmd          o_cmd
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [21:0] w_size;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    always_comb begin
        w_size = ({1'b0, i_in_item.request_bytes} + 22'd3) & ~22'd3;
        w_cmd.is_free = (i_in_item.mode == MODE_FREE);
        w_cmd.size    = w_size;
        w_cmd.where   = i_in_item.free_offset;
        w_cmd.reject  = (i_in_item.mode == MODE_ALLOC) &&
                        ((w_size == 22'd0) || (w_size > (22'd1 << ARENA_BITS)));
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) (r_cnt == 2'd2) |-> !w_push;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_cnt_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3;
    endproperty
    a_cnt_bound: assert property (p_cnt_bound) else $error("queue count out of range");

    property p_empty_ptrs;
        @(posedge i_clk) disable iff (!i_rst_n) (r_cnt == 2'd0) |-> (r_wp == r_rp);
    endproperty
    a_empty_ptrs: assert property (p_empty_ptrs) else $error("queue pointers disagree");
endmodule
`default_nettype wire

// File: hdl/fpba_back.sv
// Back part: walks the linked ledger one entry a cycle and performs splits and merges.
`default_nettype none
module fpba_back
    import fpba_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cmd_valid,
    output logic           o_cmd_ready,
    input  wire t_cmd      i_cmd,
    input  wire logic      i_init,
    input  wire logic [1:0] i_policy,
    input  wire logic [21:0] i_arena,
    output logic           o_idle,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);
    localparam int IW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [IW-1:0] NONE = IW'(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_MRG1  = 3'd3;
    localparam logic [2:0] S_MRG2  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [ARENA_BITS:0]   r_off  [MAX_ENTRIES];
    logic [ARENA_BITS+1:0] r_byt  [MAX_ENTRIES];
    logic                  r_hole [MAX_ENTRIES];
    logic                  r_used [MAX_ENTRIES];
    logic [IW-1:0]         r_prev [MAX_ENTRIES];
    logic [IW-1:0]         r_next [MAX_ENTRIES];
    logic [EW-1:0]         r_cursor;

    logic [2:0]    r_state;
    t_cmd          r_cmd;
    logic [EW-1:0] r_e, r_start, r_hit;
    logic [IW-1:0] r_pick;
    logic [CW-1:0] r_steps;
    logic [5:0]    r_count;
    logic          r_ovalid;
    t_out_item     r_out;

    logic [IW-1:0] w_free_idx;
    logic          w_fits, w_better, w_last;
    logic [IW-1:0] w_nx;
    logic [EW-1:0] w_nxe;

    always_comb begin
        w_free_idx = NONE;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        w_fits = r_used[r_e] && r_hole[r_e] && (r_byt[r_e] >= (ARENA_BITS+2)'(r_cmd.size));
        w_better = (r_pick == NONE) ||
                   ((i_policy == POL_BEST) && (r_byt[r_e] < r_byt[r_pick[EW-1:0]])) ||
                   ((i_policy == POL_WORST) && (r_byt[r_e] > r_byt[r_pick[EW-1:0]]));
        w_nx  = r_next[r_e];
        w_nxe = (w_nx >= NONE) ? EW'(0) : w_nx[EW-1:0];
        w_last = (r_steps == CW'(MAX_ENTRIES - 1));
    end

    assign o_cmd_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_idle      = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_off[i]  <= '0;
                r_byt[i]  <= '0;
                r_hole[i] <= 1'b0;
                r_used[i] <= 1'b0;
                r_prev[i] <= NONE;
                r_next[i] <= NONE;
            end
            r_byt[0]  <= (ARENA_BITS+2)'(i_arena);
            r_hole[0] <= 1'b1;
            r_used[0] <= 1'b1;
            r_cursor  <= '0;
            r_count   <= 6'd1;
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && o_cmd_ready) begin
                        r_cmd   <= i_cmd;
                        r_pick  <= NONE;
                        r_steps <= '0;
                        if (!i_cmd.is_free && i_policy == POL_NEXT && r_used[r_cursor]) begin
                            r_e     <= r_cursor;
                            r_start <= r_cursor;
                        end else begin
                            r_e     <= '0;
                            r_start <= '0;
                        end
                        if (i_cmd.reject) begin
                            r_out.status       <= ST_NOFIT;
                            r_out.block_offset <= '0;
                            r_state            <= S_DONE;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    r_steps <= r_steps + 1'b1;
                    r_e     <= w_nxe;
                    if (r_cmd.is_free) begin
                        if (r_used[r_e] && r_off[r_e] == (ARENA_BITS+1)'(r_cmd.where)) begin
                            if (r_hole[r_e]) begin
                                r_out.status       <= ST_BADFREE;
                                r_out.block_offset <= '0;
                                r_state            <= S_DONE;
                            end else begin
                                r_hole[r_e] <= 1'b1;
                                r_hit       <= r_e;
                                r_state     <= S_MRG1;
                            end
                        end else if (w_last || w_nx >= NONE) begin
                            r_out.status       <= ST_BADFREE;
                            r_out.block_offset <= '0;
                            r_state            <= S_DONE;
                        end
                    end else if (i_policy == POL_NEXT) begin
                        if (w_fits) begin
                            r_pick  <= IW'(r_e);
                            r_state <= S_ALLOC;
                        end else if (w_nxe == r_start || r_steps == CW'(MAX_ENTRIES)) begin
                            r_out.status       <= ST_NOFIT;
                            r_out.block_offset <= '0;
                            r_state            <= S_DONE;
                        end
                    end else begin
                        if (w_fits && i_policy == POL_FIRST) begin
                            r_pick  <= IW'(r_e);
                            r_state <= S_ALLOC;
                        end else begin
                            if (w_fits && w_better) begin
                                r_pick <= IW'(r_e);
                            end
                            if (w_last || w_nx >= NONE) begin
                                r_state <= S_ALLOC;
                            end
                        end
                    end
                end
                S_ALLOC: begin
                    if (r_pick == NONE) begin
                        r_out.status       <= ST_NOFIT;
                        r_out.block_offset <= '0;
                        r_state            <= S_DONE;
                    end else if (r_byt[r_pick[EW-1:0]] > (ARENA_BITS+2)'(r_cmd.size)
                                 && w_free_idx == NONE) begin
                        r_out.status       <= ST_NOENTRY;
                        r_out.block_offset <= '0;
                        r_state            <= S_DONE;
                    end else begin
                        if (r_byt[r_pick[EW-1:0]] > (ARENA_BITS+2)'(r_cmd.size)) begin
                            r_off[w_free_idx[EW-1:0]]  <= r_off[r_pick[EW-1:0]]
                                + (ARENA_BITS+1)'(r_cmd.size);
                            r_byt[w_free_idx[EW-1:0]]  <= r_byt[r_pick[EW-1:0]]
                                - (ARENA_BITS+2)'(r_cmd.size);
                            r_hole[w_free_idx[EW-1:0]] <= 1'b1;
                            r_used[w_free_idx[EW-1:0]] <= 1'b1;
                            r_prev[w_free_idx[EW-1:0]] <= r_pick;
                            r_next[w_free_idx[EW-1:0]] <= r_next[r_pick[EW-1:0]];
                            if (r_next[r_pick[EW-1:0]] < NONE) begin
                                r_prev[r_next[r_pick[EW-1:0]][EW-1:0]] <= w_free_idx;
                            end
                            r_next[r_pick[EW-1:0]] <= w_free_idx;
                            r_byt[r_pick[EW-1:0]]  <= (ARENA_BITS+2)'(r_cmd.size);
                            r_count <= r_count + 6'd1;
                        end
                        r_hole[r_pick[EW-1:0]] <= 1'b0;
                        r_cursor           <= r_pick[EW-1:0];
                        r_out.status       <= ST_OK;
                        r_out.block_offset <= r_off[r_pick[EW-1:0]][ARENA_BITS-1:0];
                        r_state            <= S_DONE;
                    end
                end
                S_MRG1: begin
                    r_state <= S_MRG2;
                    if (r_prev[r_hit] < NONE && r_used[r_prev[r_hit][EW-1:0]]
                        && r_hole[r_prev[r_hit][EW-1:0]]) begin
                        r_byt[r_prev[r_hit][EW-1:0]] <= r_byt[r_prev[r_hit][EW-1:0]]
                            + r_byt[r_hit];
                        r_next[r_prev[r_hit][EW-1:0]] <= r_next[r_hit];
                        if (r_next[r_hit] < NONE) begin
                            r_prev[r_next[r_hit][EW-1:0]] <= r_prev[r_hit];
                        end
                        r_used[r_hit] <= 1'b0;
                        r_hole[r_hit] <= 1'b0;
                        r_byt[r_hit]  <= '0;
                        r_off[r_hit]  <= '0;
                        r_prev[r_hit] <= NONE;
                        r_next[r_hit] <= NONE;
                        if (r_cursor == r_hit) begin
                            r_cursor <= r_prev[r_hit][EW-1:0];
                        end
                        r_hit   <= r_prev[r_hit][EW-1:0];
                        r_count <= r_count - 6'd1;
                    end
                end
                S_MRG2: begin
                    if (r_next[r_hit] < NONE && r_used[r_next[r_hit][EW-1:0]]
                        && r_hole[r_next[r_hit][EW-1:0]]) begin
                        r_byt[r_hit] <= r_byt[r_hit] + r_byt[r_next[r_hit][EW-1:0]];
                        r_next[r_hit] <= r_next[r_next[r_hit][EW-1:0]];
                        if (r_next[r_next[r_hit][EW-1:0]] < NONE) begin
                            r_prev[r_next[r_next[r_hit][EW-1:0]][EW-1:0]] <= IW'(r_hit);
                        end
                        r_used[r_next[r_hit][EW-1:0]] <= 1'b0;
                        r_hole[r_next[r_hit][EW-1:0]] <= 1'b0;
                        r_byt[r_next[r_hit][EW-1:0]]  <= '0;
                        r_off[r_next[r_hit][EW-1:0]]  <= '0;
                        r_prev[r_next[r_hit][EW-1:0]] <= NONE;
                        r_next[r_next[r_hit][EW-1:0]] <= NONE;
                        if (IW'(r_cursor) == r_next[r_hit]) begin
                            r_cursor <= r_hit;
                        end
                        r_count <= r_count - 6'd1;
                    end
                    r_out.status       <= ST_OK;
                    r_out.block_offset <= '0;
                    r_state            <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_out.entries_in_use <= r_count;
                        r_ovalid             <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_head_used;
        @(posedge i_clk) disable iff (!i_rst_n) r_used[0];
    endproperty
    a_head_used: assert property (p_head_used) else $error("head entry lost");

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_count != 6'd0) && (r_count <= 6'(MAX_ENTRIES));
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("entry count out of range");

    property p_ok_offset;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_ovalid && r_out.status != ST_OK) |-> (r_out.block_offset == '0);
    endproperty
    a_ok_offset: assert property (p_ok_offset) else $error("offset on failed item");
endmodule
`default_nettype wire
